@@ hdl/pud_pkg.sv @@
// ============================================================================
// pud_pkg - percent decoder shared types and constants
// Character codes, hex helpers and the queue entry passed front to back.
// ============================================================================
`default_nettype none

package pud_pkg;

    localparam int unsigned MAX_BYTES = 3;

    localparam logic [7:0] CHAR_PCT   = 8'h25;  // '%'
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;

    localparam logic [3:0] HEX_ALPHA_ADJ = 4'h9;  // 'a'/'A' low nibble 1 -> 10

    // One item's worth of decoded bytes, count is 1..3 once queued
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [1:0]                count;
        logic                      last;
    } t_entry;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CHAR_0  && c <= CHAR_9)  ||
               (c >= CHAR_UA && c <= CHAR_UF) ||
               (c >= CHAR_LA && c <= CHAR_LF);
    endfunction

    // Digits have bit 4 set, letters do not
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        return c[4] ? c[3:0] : c[3:0] + HEX_ALPHA_ADJ;
    endfunction

endpackage

`default_nettype wire

@@ hdl/pud_if.sv @@
// ============================================================================
// pud_if - percent decoder stream channels
// Valid/ready channels for raw characters in and decoded bytes out.
// ============================================================================
`default_nettype none

interface pud_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       string_end;

    modport source (output valid, output in_char, output string_end, input ready);
    modport sink   (input valid, input in_char, input string_end, output ready);
endinterface

interface pud_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

@@ hdl/percent_url_decoder.sv @@
// ============================================================================
// percent_url_decoder - streaming URL percent decoder
// '%'+two hex digits -> one byte, '+' -> space, the rest passes through.
// ============================================================================
//
// Channel   Dir  Payload                    Transfer
// --------  ---  -------------------------  -------------------------------
// i_in      in   in_char[7:0], string_end   valid & ready, one char each
// o_out     out  out_byte[7:0], out_last    valid & ready, one byte each
//
// Cycles: one character per cycle while each yields at most one byte and
//   o_out is not stalled. A character that releases k bytes (flushed '%' and
//   held digit) keeps the back end busy until all k are out; the
//   serializer's one-byte-per-cycle output register sets the sustained rate.
// Path: a character's bytes pass through the queue, then the o_out register.
// Reset: synchronous, active low; clears escape phase, queue and output valid.
// Stalls: the two-entry queue absorbs output backpressure; i_in.ready drops
//   only when it is full.
// ============================================================================
`default_nettype none

module percent_url_decoder (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pud_in_if.sink    i_in,
    pud_out_if.source o_out
);

    // front -> queue
    logic            push_valid;
    logic            push_ready;
    pud_pkg::t_entry push_entry;

    // queue -> back
    logic            head_valid;
    pud_pkg::t_entry head_entry;
    logic            pop;

    // Front: escape phase tracking, classifies each char into a byte group
    pud_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_entry (push_entry),
        .i_push_ready (push_ready)
    );

    // Decouples classification from byte output
    pud_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_entry (push_entry),
        .o_push_ready (push_ready),
        .o_head_valid (head_valid),
        .o_head_entry (head_entry),
        .i_pop        (pop)
    );

    // Back: serializes each group, tags end of string on its final byte
    pud_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_entry (head_entry),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

@@ hdl/pud_front.sv @@
// ============================================================================
// pud_front - escape tracking and classification
// Accepts characters, tracks the escape phase and builds 0..3 output bytes.
// ============================================================================
`default_nettype none

module pud_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    pud_in_if.sink                i_in,
    output      logic             o_push_valid,
    output      pud_pkg::t_entry  o_push_entry,
    input  wire logic             i_push_ready
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_held,  n_held;

    logic       accept;
    logic       c_hex;
    logic       plain_pct;
    logic       plain_emit;
    logic [7:0] plain_byte;
    pud_pkg::t_entry entry;

    assign i_in.ready = i_push_ready;
    assign accept     = i_in.valid && i_push_ready;

    always_comb begin
        c_hex      = pud_pkg::is_hex(i_in.in_char);
        // '%' not at the end opens a sequence and emits nothing
        plain_pct  = (i_in.in_char == pud_pkg::CHAR_PCT) && !i_in.string_end;
        plain_emit = !plain_pct;
        plain_byte = (i_in.in_char == pud_pkg::CHAR_PLUS) ? pud_pkg::CHAR_SPACE
                                                          : i_in.in_char;
        entry       = '0;
        entry.last  = i_in.string_end;
        n_held      = r_held;
        n_phase     = plain_pct ? PH_PCT : PH_IDLE;

        unique case (r_phase)
            PH_PCT: begin
                if (c_hex && !i_in.string_end) begin
                    n_phase     = PH_DIGIT;
                    n_held      = i_in.in_char;
                    entry.count = 2'd0;
                end else begin
                    entry.bytes[0] = pud_pkg::CHAR_PCT;
                    entry.bytes[1] = plain_byte;
                    entry.count    = plain_emit ? 2'd2 : 2'd1;
                end
            end
            PH_DIGIT: begin
                if (c_hex) begin
                    n_phase        = PH_IDLE;
                    entry.bytes[0] = {pud_pkg::hex_value(r_held),
                                      pud_pkg::hex_value(i_in.in_char)};
                    entry.count    = 2'd1;
                end else begin
                    // broken: flush '%' and digit, then char (none if '%' opens)
                    entry.bytes[0] = pud_pkg::CHAR_PCT;
                    entry.bytes[1] = r_held;
                    entry.bytes[2] = plain_byte;
                    entry.count    = plain_emit ? 2'd3 : 2'd2;
                end
            end
            default: begin
                entry.bytes[0] = plain_byte;
                entry.count    = plain_emit ? 2'd1 : 2'd0;
            end
        endcase
    end

    assign o_push_valid = accept && (entry.count != 2'd0);
    assign o_push_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

`default_nettype wire

@@ hdl/pud_queue.sv @@
// ============================================================================
// pud_queue - two-entry queue between front and back
// Holds decoded byte groups so front and back stall independently.
// ============================================================================
`default_nettype none

module pud_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    input  wire pud_pkg::t_entry  i_push_entry,
    output      logic             o_push_ready,
    output      logic             o_head_valid,
    output      pud_pkg::t_entry  o_head_entry,
    input  wire logic             i_pop
);

    pud_pkg::t_entry r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head_entry = r_mem[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= !r_wr_ptr;
            if (pop)  r_rd_ptr <= !r_rd_ptr;
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/pud_back.sv @@
// ============================================================================
// pud_back - byte serializer and output register
// Moves the head entry into the output register, one byte per unstalled cycle.
// ============================================================================
`default_nettype none

module pud_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_head_valid,
    input  wire pud_pkg::t_entry  i_head_entry,
    output      logic             o_pop,
    pud_out_if.source             o_out
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;
    logic       final_byte;

    assign load       = i_head_valid && (!r_valid || o_out.ready);
    assign final_byte = (r_idx == (i_head_entry.count - 2'd1));
    assign o_pop      = load && final_byte;

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.out_last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= final_byte ? 2'd0 : r_idx + 2'd1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head_entry.bytes[r_idx];
            r_last <= i_head_entry.last && final_byte;
        end
    end

endmodule

`default_nettype wire

@@ hdl/pud_checker.sv @@
// ============================================================================
// pud_checker - port-level checks for the percent decoder
// Reset behavior and output hold under backpressure.
// ============================================================================
`default_nettype none

module pud_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_last
);

    // reset empties the output register
    a_rst_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // reset empties the queue, so input is ready
    a_rst_in_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    // stalled byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("output changed while stalled");

    // a full queue only arises with bytes waiting at the output
    a_full_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input blocked with output empty");

endmodule

bind percent_url_decoder pud_checker u_pud_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last)
);

`default_nettype wire

@@ tb/percent_url_decoder_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// percent_url_decoder_checker - in-order scoreboard for the percent decoder
// Watches both channels, predicts the decoded bytes of every input transfer
// and compares each output transfer, byte and last flag, with the oldest one.
// ============================================================================

module percent_url_decoder_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pud_in_if         i_in,
    pud_out_if        i_out,
    output int        o_fail_count,
    output int        o_pending
);

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2
    } t_esc_state;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_dec_byte;

    t_esc_state esc_state = ESC_NONE;
    logic [7:0] held_char = '0;
    t_dec_byte  expected_bytes[$];
    int         emitted;
    int         fails = 0;

    // {is hex digit, nibble value}
    function automatic logic [4:0] hex_lookup(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= "0" && c <= "9")
            return {1'b1, c[3:0]};
        if (folded >= "a" && folded <= "f")
            return {1'b1, c[3:0] + 4'd9};
        return 5'd0;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        t_dec_byte entry;
        entry.data = b;
        entry.last = 1'b0;
        expected_bytes.push_back(entry);
        emitted++;
    endfunction

    // Character seen with nothing held
    function automatic void plain_char(input logic [7:0] c, input logic fin);
        if (c == pud_pkg::CHAR_PCT && !fin)
            esc_state = ESC_PCT;
        else if (c == pud_pkg::CHAR_PLUS)
            push_byte(pud_pkg::CHAR_SPACE);
        else
            push_byte(c);
    endfunction

    function automatic void predict_decode(input logic [7:0] c, input logic fin);
        logic [4:0] lo;
        logic [4:0] hi;
        t_esc_state prior;
        t_dec_byte  tail;
        lo        = hex_lookup(c);
        prior     = esc_state;
        esc_state = ESC_NONE;
        emitted   = 0;
        case (prior)
            ESC_PCT: begin
                if (lo[4] && !fin) begin
                    esc_state = ESC_DIGIT;
                    held_char = c;
                end else begin
                    push_byte(pud_pkg::CHAR_PCT);
                    plain_char(c, fin);
                end
            end
            ESC_DIGIT: begin
                if (lo[4]) begin
                    hi = hex_lookup(held_char);
                    push_byte({hi[3:0], lo[3:0]});
                end else begin
                    push_byte(pud_pkg::CHAR_PCT);
                    push_byte(held_char);
                    plain_char(c, fin);
                end
            end
            default: plain_char(c, fin);
        endcase
        // end of string: drop anything held, flag the final byte
        if (fin) begin
            esc_state = ESC_NONE;
            if (emitted > 0) begin
                tail      = expected_bytes.pop_back();
                tail.last = 1'b1;
                expected_bytes.push_back(tail);
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fails++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_dec_byte want;
        if (!i_rst_n) begin
            esc_state = ESC_NONE;
            held_char = '0;
            expected_bytes.delete();
        end else begin
            if (i_in.valid && i_in.ready)
                predict_decode(i_in.in_char, i_in.string_end);
            if (i_out.valid && i_out.ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %h last %b",
                                              i_out.out_byte, i_out.out_last));
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out.out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %h, want %h",
                                                  i_out.out_byte, want.data));
                    if (i_out.out_last !== want.last)
                        report_mismatch($sformatf("out_last %b, want %b (byte %h)",
                                                  i_out.out_last, want.last, want.data));
                end
            end
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= fails;
    end

endmodule

@@ tb/percent_url_decoder_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// percent_url_decoder_tb - stimulus and verdict for the percent decoder
// Directed strings hit each escape corner, then random strings made mostly of
// well-formed escapes run with random gaps on both channels, one long output
// hold-off and drain pauses. The checker module scores every transfer.
// ============================================================================

module percent_url_decoder_tb;

    localparam int CLK_HALF_NS  = 6;       // 12 ns period
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 210;
    localparam int HOLD_CYCLES  = 120;     // long output hold-off
    localparam int BURST_ESC    = 8;       // escapes offered during the hold-off
    localparam int DRAIN_CYCLES = 8;       // settle time after the last byte
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pud_in_if  in_ch ();
    pud_out_if out_ch ();

    int         fail_count;
    int         pending;
    int         sent_items = 0;
    int         cycle_count = 0;
    bit         no_gaps = 1'b0;       // sender offers back to back
    bit         hold_request = 1'b0;  // sender asks receiver for a long hold-off
    bit         hold_active = 1'b0;   // receiver is in the hold-off
    logic [7:0] text_q[$];            // characters of the string being sent

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    percent_url_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    percent_url_decoder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Any of the 22 hex digit characters, both cases
    function automatic logic [7:0] rand_hex();
        int idx;
        idx = $urandom_range(0, 21);
        if (idx < 10)
            return 8'("0" + idx);
        if (idx < 16)
            return 8'("a" + idx - 10);
        return 8'("A" + idx - 16);
    endfunction

    // One character transfer. The gap, if any, drops valid first; with no gap
    // valid just stays high and the payload changes, so valid sees one
    // nonblocking write per edge. ready is read right after the edge, i.e.
    // its value at that edge.
    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_char    <= c;
        in_ch.string_end <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_items++;
    endtask

    // Send text_q as one string, end mark on its final character
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic load_text(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // Stop offering and wait for every predicted byte. The first edge lets
    // the checker count the transfer that happened at the current edge.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Random string built from tokens; half the tokens are full escapes
    task automatic build_random_text();
        int tokens;
        text_q.delete();
        tokens = $urandom_range(1, 6);
        repeat (tokens) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    text_q.push_back(pud_pkg::CHAR_PCT);
                    text_q.push_back(rand_hex());
                    text_q.push_back(rand_hex());
                end
                5: text_q.push_back(pud_pkg::CHAR_PLUS);
                6: text_q.push_back(8'($urandom_range(0, 255)));
                7: text_q.push_back(pud_pkg::CHAR_PCT);
                8: text_q.push_back(rand_hex());
                default: begin
                    // escape broken (or not) by its second digit
                    text_q.push_back(pud_pkg::CHAR_PCT);
                    text_q.push_back(rand_hex());
                    text_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // Output side: random ready with short and long stalls, long runs with
    // no stall, and the long hold-off on request.
    initial begin : receiver
        int run;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                              : $urandom_range(1, 20);
            repeat (run) @(posedge i_clk);
        end
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int target;
        int strings;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.in_char    <= '0;
        in_ch.string_end <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed strings ----
        load_text("%2F+");      // upper-case escape, plus as final char
        send_text();
        load_text("%ff");       // lower-case escape completes on the end mark
        send_text();
        load_text("%");         // lone percent is the whole string
        send_text();
        load_text("%4");        // string ends after '%' and one digit
        send_text();
        load_text("%4%g");      // percent breaks a half escape, 'g' breaks the next
        send_text();
        load_text("%a+");       // one char releases three bytes
        send_text();
        load_text("%z%+");      // non-hex and plus each break a held percent
        text_q.push_back(8'h80);
        text_q.push_back(8'hFF);
        text_q.push_back(8'h00);
        send_text();
        wait_idle();

        // ---- output hold-off while the sender keeps pushing ----
        hold_request = 1'b1;
        wait (hold_active);
        @(posedge i_clk);
        no_gaps = 1'b1;
        text_q.delete();
        repeat (BURST_ESC) begin
            text_q.push_back(pud_pkg::CHAR_PCT);
            text_q.push_back(rand_hex());
            text_q.push_back(rand_hex());
        end
        text_q.push_back(pud_pkg::CHAR_PLUS);
        send_text();
        no_gaps = 1'b0;
        wait_idle();

        // ---- random strings ----
        target  = sent_items + RANDOM_ITEMS;
        strings = 0;
        while (sent_items < target) begin
            build_random_text();
            no_gaps = ($urandom_range(0, 4) == 0);
            send_text();
            strings++;
            // pause now and then until all bytes are out
            if (strings % 10 == 0)
                wait_idle();
        end
        no_gaps = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/pud_pkg.sv
hdl/pud_if.sv
hdl/pud_front.sv
hdl/pud_queue.sv
hdl/pud_back.sv
hdl/percent_url_decoder.sv
hdl/pud_checker.sv
tb/percent_url_decoder_checker.sv
tb/percent_url_decoder_tb.sv
